>>> hdl/deq_pkg.sv
// ============================================================================
// deq_pkg: shared types and constants for the double-ended queue
// Holds the transaction payloads, operation and status codes, and the
// plan that the pointer unit hands to the top level.
// ============================================================================
`default_nettype none

package deq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the transactions.
    localparam int KIND_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Stored element width: the value field carries at most FIELD_W bits.
    localparam int ELEM_W = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam logic [KIND_W-1:0] KIND_PUSH_TOP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BOTTOM = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_TOP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BOTTOM  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [FIELD_W-1:0]  top_value;
        logic [FIELD_W-1:0]  bottom_value;
    } res_t;

    // Decisions for one command, taken from the current indices and count.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                set_top;
        logic                set_bottom;
        logic                pop_top;
        logic                pop_bottom;
    } deq_plan_t;

endpackage

`default_nettype wire

>>> hdl/double_ended_queue_core.sv
// ============================================================================
// double_ended_queue_core: bounded double-ended queue in a circular buffer
// Results are registered; a pop that leaves at least one element passes
// through S_READ first, since the new end element comes from the RAM.
// Throughput: one command per cycle while results are taken, except that
// such pops hold off the next command; the single registered RAM read sets that.
// Reset: indices and count clear at once; the element RAM is not cleared.
// ============================================================================
`default_nettype none

module double_ended_queue_core
    import deq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    // The controller waits in its own state only while a pop reads the
    // element that becomes the new top or bottom end.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    deq_plan_t        plan;
    logic             cmd_fire;
    logic [ELEM_W-1:0] elem;
    logic [ELEM_W-1:0] rd_data;

    // Cached end elements, so that every result can report both ends
    // without a second memory port.
    logic [ELEM_W-1:0] top_val_reg;
    logic [ELEM_W-1:0] bottom_val_reg;
    logic [ELEM_W-1:0] top_now;
    logic [ELEM_W-1:0] bottom_now;
    logic [ELEM_W-1:0] popped_now;

    // Details of a pop waiting on its read.
    logic [ELEM_W-1:0] pend_popped_reg;
    logic [CNT_W-1:0]  pend_count_reg;
    logic              pend_top_reg;

    logic res_valid_reg, res_valid_next;
    res_t res_reg;

    assign elem = ELEM_W'(cmd.value);

    // A new transaction is taken in S_IDLE whenever the result register is free or
    // is being emptied in this cycle.
    assign cmd_ready = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    deq_ptr u_ptr (
        .clk    (clk),
        .rst_n  (rst_n),
        .kind   (cmd.kind),
        .commit (cmd_fire),
        .plan   (plan)
    );

    deq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd_fire && plan.wr_en),
        .wr_addr (plan.wr_addr),
        .wr_data (elem),
        .rd_en   (cmd_fire && plan.rd_en),
        .rd_addr (plan.rd_addr),
        .rd_data (rd_data)
    );

    // End elements as they stand after a command that needs no read.
    assign top_now    = plan.set_top ? elem : top_val_reg;
    assign bottom_now = plan.set_bottom ? elem : bottom_val_reg;

    always_comb
    begin
        priority if (plan.pop_top)
        begin
            popped_now = top_val_reg;
        end
        else if (plan.pop_bottom)
        begin
            popped_now = bottom_val_reg;
        end
        else
        begin
            popped_now = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && plan.rd_en)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd_fire && !plan.rd_en)
        begin
            res_valid_next = 1'b1;
        end
        else if (state_reg == S_READ)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and cache registers carry no reset: a cached end is read
    // only while the queue holds elements, and by then it has been written.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            if (plan.set_top)
            begin
                top_val_reg <= elem;
            end
            if (plan.set_bottom)
            begin
                bottom_val_reg <= elem;
            end
            pend_popped_reg <= popped_now;
            pend_count_reg  <= plan.count;
            pend_top_reg    <= plan.pop_top;
            if (!plan.rd_en)
            begin
                res_reg.popped       <= FIELD_W'(popped_now);
                res_reg.status       <= plan.status;
                res_reg.count        <= COUNT_W'(plan.count);
                res_reg.top_value    <= (plan.count != '0) ? FIELD_W'(top_now) : '0;
                res_reg.bottom_value <= (plan.count != '0) ? FIELD_W'(bottom_now) : '0;
            end
        end
        else if (state_reg == S_READ)
        begin
            // The element read from the RAM becomes the new end of the pop.
            if (pend_top_reg)
            begin
                top_val_reg <= rd_data;
            end
            else
            begin
                bottom_val_reg <= rd_data;
            end
            res_reg.popped       <= FIELD_W'(pend_popped_reg);
            res_reg.status       <= ST_OK;
            res_reg.count        <= COUNT_W'(pend_count_reg);
            res_reg.top_value    <= FIELD_W'(pend_top_reg ? rd_data : top_val_reg);
            res_reg.bottom_value <= FIELD_W'(pend_top_reg ? bottom_val_reg : rd_data);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // While a pop waits on its read, no earlier result may still be pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !res_valid_reg)
        else $error("result pending while a pop read is outstanding");

    // A pop that reads the RAM always delivers its result once S_READ is left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && plan.rd_en) |=> ##1 res_valid_reg)
        else $error("pop read did not produce a result");

    // An empty queue reports both ends as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.count == '0) |->
            (res_reg.top_value == '0 && res_reg.bottom_value == '0))
        else $error("empty queue reports nonzero end elements");

    // A refused push is only reported against a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_FULL) |->
            (res_reg.count == COUNT_W'(CAPACITY)))
        else $error("full status without a full queue");

endmodule

`default_nettype wire

>>> hdl/deq_ram.sv
// ============================================================================
// deq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/deq_ptr.sv
// ============================================================================
// deq_ptr: index and count keeper of the double-ended queue
// Decodes each command against the top index, bottom index and element
// count, plans the memory access and updates the indices on commit.
// ============================================================================
`default_nettype none

module deq_ptr
    import deq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic              commit,
    output deq_plan_t              plan
);

    logic [IDX_W-1:0] top_idx_reg, top_idx_next;
    logic [IDX_W-1:0] bot_idx_reg, bot_idx_next;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [IDX_W-1:0] slot_up(input logic [IDX_W-1:0] i);
        slot_up = (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] slot_down(input logic [IDX_W-1:0] i);
        slot_down = (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
    endfunction

    always_comb
    begin
        plan         = '0;
        plan.status  = ST_OK;
        plan.count   = count_reg;
        top_idx_next = top_idx_reg;
        bot_idx_next = bot_idx_reg;
        unique case (kind)
            KIND_PUSH_TOP, KIND_PUSH_BOTTOM:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    plan.status = ST_FULL;
                end
                else if (count_reg == '0)
                begin
                    // First element lands in the slot both indices share.
                    plan.wr_en      = 1'b1;
                    plan.wr_addr    = top_idx_reg;
                    plan.set_top    = 1'b1;
                    plan.set_bottom = 1'b1;
                    plan.count      = CNT_W'(1);
                    bot_idx_next    = top_idx_reg;
                end
                else if (kind == KIND_PUSH_TOP)
                begin
                    top_idx_next = slot_up(top_idx_reg);
                    plan.wr_en   = 1'b1;
                    plan.wr_addr = slot_up(top_idx_reg);
                    plan.set_top = 1'b1;
                    plan.count   = count_reg + 1'b1;
                end
                else
                begin
                    bot_idx_next    = slot_down(bot_idx_reg);
                    plan.wr_en      = 1'b1;
                    plan.wr_addr    = slot_down(bot_idx_reg);
                    plan.set_bottom = 1'b1;
                    plan.count      = count_reg + 1'b1;
                end
            end
            KIND_POP_TOP, KIND_POP_BOTTOM:
            begin
                if (count_reg == '0)
                begin
                    plan.status = ST_EMPTY;
                end
                else
                begin
                    plan.count      = count_reg - 1'b1;
                    plan.pop_top    = (kind == KIND_POP_TOP);
                    plan.pop_bottom = (kind == KIND_POP_BOTTOM);
                    // The last element leaves both indices in place.
                    if (count_reg > CNT_W'(1))
                    begin
                        plan.rd_en = 1'b1;
                        if (kind == KIND_POP_TOP)
                        begin
                            top_idx_next = slot_down(top_idx_reg);
                            plan.rd_addr = slot_down(top_idx_reg);
                        end
                        else
                        begin
                            bot_idx_next = slot_up(bot_idx_reg);
                            plan.rd_addr = slot_up(bot_idx_reg);
                        end
                    end
                end
            end
            KIND_CLEAR:
            begin
                if (count_reg == '0)
                begin
                    plan.status = ST_EMPTY;
                end
                else
                begin
                    plan.count   = '0;
                    bot_idx_next = top_idx_reg;
                end
            end
            default:
            begin
                plan.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_idx_reg <= '0;
            bot_idx_reg <= '0;
            count_reg   <= '0;
        end
        else if (commit)
        begin
            top_idx_reg <= top_idx_next;
            bot_idx_reg <= bot_idx_next;
            count_reg   <= plan.count;
        end
    end

endmodule

`default_nettype wire

>>> sim/double_ended_queue_core_tb.sv
// ============================================================================
// double_ended_queue_core_tb: self-checking bench for the double-ended queue
// Pushes, pops, clears and no-op kinds go into the command channel under
// random gaps and result back-pressure. A scoreboard class keeps its own
// copy of the queue and checks every result field, in order.
// ============================================================================
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int REPORT_LIMIT = 30;
    localparam int DRAIN_TAIL   = 10;

    // Accepted-transaction marks at which the pressure events and the
    // calm stretch take place.
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int PAUSE_AT     = 700;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1100;

    // Kinds above clear are decoded as no-ops.
    localparam logic [KIND_W-1:0] KIND_NOOP_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOOP_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NOOP_LAST  = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow double-ended queue that computes the expected
    // result of every accepted command and checks results as they arrive.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [ELEM_W-1:0] slots [CAPACITY];
        int unsigned top_slot;
        int unsigned bottom_slot;
        int unsigned held;
        res_t        expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned full_refusals;
        int unsigned empty_errors;
        int unsigned peak;

        function new();
            foreach (slots[i]) slots[i] = '0;
            top_slot      = 0;
            bottom_slot   = 0;
            held          = 0;
            mismatches    = 0;
            checked       = 0;
            full_refusals = 0;
            empty_errors  = 0;
            peak          = 0;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function void note_command(cmd_t c);
            res_t              r;
            logic [ELEM_W-1:0] elem;
            elem = c.value[ELEM_W-1:0];
            r = '0;
            r.status = ST_OK;
            case (c.kind)
                KIND_PUSH_TOP, KIND_PUSH_BOTTOM:
                begin
                    if (held >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end
                    else if (held == 0)
                    begin
                        slots[top_slot] = elem;
                        bottom_slot = top_slot;
                        held = 1;
                    end
                    else if (c.kind == KIND_PUSH_TOP)
                    begin
                        top_slot = (top_slot + 1) % CAPACITY;
                        slots[top_slot] = elem;
                        held++;
                    end
                    else
                    begin
                        bottom_slot = (bottom_slot + CAPACITY - 1) % CAPACITY;
                        slots[bottom_slot] = elem;
                        held++;
                    end
                end
                KIND_POP_TOP, KIND_POP_BOTTOM:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_errors++;
                    end
                    else if (c.kind == KIND_POP_TOP)
                    begin
                        r.popped = FIELD_W'(slots[top_slot]);
                        // The last element leaves both indices in place.
                        if (held > 1)
                            top_slot = (top_slot + CAPACITY - 1) % CAPACITY;
                        held--;
                    end
                    else
                    begin
                        r.popped = FIELD_W'(slots[bottom_slot]);
                        if (held > 1)
                            bottom_slot = (bottom_slot + 1) % CAPACITY;
                        held--;
                    end
                end
                KIND_CLEAR:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_errors++;
                    end
                    else
                    begin
                        held = 0;
                        bottom_slot = top_slot;
                    end
                end
                default:
                begin
                end
            endcase
            r.count = COUNT_W'(held);
            if (held != 0)
            begin
                r.top_value    = FIELD_W'(slots[top_slot]);
                r.bottom_value = FIELD_W'(slots[bottom_slot]);
            end
            if (held > peak)
                peak = held;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [FIELD_W-1:0] want,
                                    logic [FIELD_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %0d field %s expected %h actual %h",
                             $time, checked, name, want, got);
            end
        endfunction

        function void check_result(res_t r);
            res_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, r);
                return;
            end
            want = expected_q.pop_front();
            compare_field("popped", want.popped, r.popped);
            compare_field("status", FIELD_W'(want.status), FIELD_W'(r.status));
            compare_field("count", FIELD_W'(want.count), FIELD_W'(r.count));
            compare_field("top_value", want.top_value, r.top_value);
            compare_field("bottom_value", want.bottom_value, r.bottom_value);
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    deque_scoreboard sb;
    int unsigned     cycle_count;
    int unsigned     accepted_cmds;
    bit              hold_done;

    double_ended_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Inside the calm stretch neither side inserts bubbles.
    function automatic bit in_calm_stretch();
        return accepted_cmds >= CALM_FROM && accepted_cmds < CALM_TO;
    endfunction

    // Both channels are observed here, at the rising edge. A command is noted
    // before a result of the same edge is checked, so a result can never be
    // compared ahead of the command that caused it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                sb.note_command(cmd);
                accepted_cmds <= accepted_cmds + 1;
            end
            if (res_valid && res_ready)
                sb.check_result(res);
        end
    end

    // Result side. Ready toggles at random, except for one long hold-off
    // while the sender keeps offering commands, so the block backs up and
    // drops cmd_ready.
    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_cmds >= HOLD_AT)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (in_calm_stretch())
                res_ready <= 1'b1;
            else
                res_ready <= ($urandom_range(99) >= 25);
        end
    end

    // Offers one command transaction. It is entered and left at a falling
    // edge; an optional gap of idle cycles goes first. Valid is raised once
    // and stays high until the transaction is taken.
    task automatic send_command(input logic [KIND_W-1:0] kind,
                                input logic [FIELD_W-1:0] value);
        cmd_t c;
        c.kind  = kind;
        c.value = value;
        if (!in_calm_stretch() && $urandom_range(99) < 25)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < 25)
                @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        @(negedge clk);
    endtask

    // Drops valid and waits at falling edges until no result is outstanding.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // A filling phase issues no clears, so that it reliably reaches full.
    function automatic logic [KIND_W-1:0] pick_kind(mix_e mix);
        int unsigned r;
        int unsigned push_pct;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  push_pct = 90;
            MIX_DRAIN: push_pct = 10;
            default:   push_pct = 48;
        endcase
        if (r < push_pct)
            return $urandom_range(1) ? KIND_PUSH_TOP : KIND_PUSH_BOTTOM;
        else if (r < 95)
            return $urandom_range(1) ? KIND_POP_TOP : KIND_POP_BOTTOM;
        else if (r < 97 && mix != MIX_FILL)
            return KIND_CLEAR;
        else
            return KIND_W'(KIND_NOOP_FIRST +
                           $urandom_range(KIND_NOOP_LAST - KIND_NOOP_FIRST));
    endfunction

    // Element values lean toward the all-zero and all-one patterns.
    function automatic logic [FIELD_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else
            return $urandom;
    endfunction

    initial
    begin
        cycle_count   = 0;
        accepted_cmds = 0;
        hold_done     = 1'b0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("double_ended_queue_core verification failed");
        $finish;
    end

    initial
    begin
        mix_e        mix;
        int unsigned sent;
        int unsigned span;
        bit          paused;

        sb        = new();
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        paused    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: operations on an empty queue, the no-op kinds, the
        // last element leaving from either end, extreme element values and a
        // clear of a populated queue.
        send_command(KIND_POP_TOP, 32'h0000_0000);
        send_command(KIND_POP_BOTTOM, 32'hFFFF_FFFF);
        send_command(KIND_CLEAR, 32'h0000_0000);
        send_command(KIND_NOOP_FIRST, 32'hFFFF_FFFF);
        send_command(KIND_NOOP_MID, 32'h1234_5678);
        send_command(KIND_NOOP_LAST, 32'hFFFF_FFFF);
        send_command(KIND_PUSH_TOP, 32'h0000_0000);
        send_command(KIND_POP_TOP, 32'h0000_0000);
        send_command(KIND_PUSH_BOTTOM, 32'hFFFF_FFFF);
        send_command(KIND_POP_BOTTOM, 32'h0000_0000);
        send_command(KIND_PUSH_TOP, 32'h0000_0001);
        send_command(KIND_PUSH_TOP, 32'h8000_0000);
        send_command(KIND_PUSH_BOTTOM, 32'hFFFF_FFFF);
        send_command(KIND_PUSH_BOTTOM, 32'h7FFF_FFFF);
        send_command(KIND_NOOP_FIRST, 32'h0000_0000);
        send_command(KIND_POP_TOP, 32'hFFFF_FFFF);
        send_command(KIND_POP_BOTTOM, 32'h0000_0000);
        send_command(KIND_CLEAR, 32'hFFFF_FFFF);
        send_command(KIND_POP_TOP, 32'h0000_0000);
        send_command(KIND_PUSH_BOTTOM, 32'hA5A5_A5A5);
        send_command(KIND_PUSH_TOP, 32'h5A5A_5A5A);
        send_command(KIND_POP_TOP, 32'h0000_0000);
        send_command(KIND_POP_TOP, 32'h0000_0000);
        send_command(KIND_POP_BOTTOM, 32'h0000_0000);

        // Random part in phases of varying mix. The first two phases fill
        // the queue past full and then drain it past empty; after that the
        // mix is drawn at random.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0)
                mix = MIX_FILL;
            else if (sent < 200)
                mix = MIX_DRAIN;
            else
                mix = mix_e'($urandom_range(2));
            span = $urandom_range(40, 160);
            if (sent < 200)
                span = 100;
            if (span > RANDOM_ITEMS - sent)
                span = RANDOM_ITEMS - sent;
            repeat (span)
            begin
                // The sender stops once to let every result come home.
                if (!paused && accepted_cmds >= PAUSE_AT)
                begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                send_command(pick_kind(mix), pick_value());
                sent++;
            end
        end

        wait_for_drain();
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("Checked %0d results over %0d commands: %0d full refusals, %0d empty errors,",
                 sb.checked, accepted_cmds, sb.full_refusals, sb.empty_errors);
        $display("peak occupancy %0d of %0d, with random stalls and one long result hold-off.",
                 sb.peak, CAPACITY);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("double_ended_queue_core verification clean");
        else
            $display("double_ended_queue_core verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ptr.sv
hdl/double_ended_queue_core.sv
sim/double_ended_queue_core_tb.sv
